// ----- hdl/ptc_pkg.sv -----
// Shared types and constants of the pressure and temperature compensation block.
// Used by every other file of the block; depends on nothing.
package ptc_pkg;

    // Field widths
    localparam int RAW_T_W = 16;
    localparam int RAW_P_W = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 15;
    localparam int PRESS_W = 21;

    // Datapath widths
    localparam int TSQ_W   = 31;   // square of the centered temperature
    localparam int QUAD_W  = 23;   // quadratic term after the 2^24 scaling
    localparam int SENS_W  = 28;   // widest sensitivity (middle point)
    localparam int DIFF_W  = 29;   // signed differences of sensitivities
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int NUM_W   = 60;   // signed numerator and divisor
    localparam int MAG_W   = NUM_W - 1;
    localparam int KMUL_W  = 22;   // 15000 << frac bits, up to eight frac bits
    localparam int SPLIT_W = 30;   // low slice of the magnitude for the scaling multiply
    localparam int SCALED_W = MAG_W + KMUL_W;

    // Calibration constants
    localparam logic [23:0]        SENS_LOW_BASE  = 24'd3670016;
    localparam logic [23:0]        SENS_HIGH_BASE = 24'd12058624;
    localparam logic [14:0]        TEMP_SCALE     = 15'd17500;
    localparam logic signed [15:0] TEMP_OFFSET    = 16'sd4500;
    localparam logic [PRESS_W-1:0] PRESS_MAX      = '1;

    // Register indexes
    localparam logic [1:0] REG_SENS_LOW  = 2'd0;
    localparam logic [1:0] REG_SENS_MID  = 2'd1;
    localparam logic [1:0] REG_SENS_HIGH = 2'd2;
    localparam logic [1:0] REG_OFFSET    = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [COEF_W-1:0] sens_low;
        logic [COEF_W-1:0] sens_mid;
        logic [COEF_W-1:0] sens_high;
        logic [COEF_W-1:0] offset;
    } ptc_coef_t;

    // One classified item between front and back
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [MAG_W-1:0]         num_mag;
        logic [MAG_W-1:0]         den_mag;
        logic                     div_fault;
        logic                     positive;
    } ptc_item_t;

endpackage

// ----- hdl/ptc_sample_if.sv -----
// Input channel of raw sample pairs.
// Depends on ptc_pkg for the field widths.
interface ptc_sample_if;
    logic                            valid;
    logic                            ready;
    logic [ptc_pkg::RAW_T_W-1:0]     raw_temp;
    logic [ptc_pkg::RAW_P_W-1:0]     raw_press;

    modport source (output valid, output raw_temp, output raw_press, input ready);
    modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

// ----- hdl/ptc_result_if.sv -----
// Output channel of compensated results.
// Depends on ptc_pkg for the field widths.
interface ptc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptc_pkg::TEMP_W-1:0]   temp_centi;
    logic [ptc_pkg::PRESS_W-1:0]         press_fixed;
    logic                                div_fault;

    modport source (output valid, output temp_centi, output press_fixed, output div_fault,
                    input ready);
    modport sink (input valid, input temp_centi, input press_fixed, input div_fault,
                  output ready);
endinterface

// ----- hdl/ptc_regs.sv -----
// APB register file holding the four factory calibration words.
// Depends on ptc_pkg.
module ptc_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output ptc_pkg::ptc_coef_t                 coef
);

    ptc_pkg::ptc_coef_t coef_reg;
    logic [1:0]         index;
    logic               wr_en;
    logic [ptc_pkg::COEF_W-1:0] rd_word;

    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coef   = coef_reg;

    // Write the addressed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                ptc_pkg::REG_SENS_LOW:  coef_reg.sens_low  <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_SENS_MID:  coef_reg.sens_mid  <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_SENS_HIGH: coef_reg.sens_high <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_OFFSET:    coef_reg.offset    <= pwdata[ptc_pkg::COEF_W-1:0];
                default:                coef_reg           <= coef_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (index)
            ptc_pkg::REG_SENS_LOW:  rd_word = coef_reg.sens_low;
            ptc_pkg::REG_SENS_MID:  rd_word = coef_reg.sens_mid;
            ptc_pkg::REG_SENS_HIGH: rd_word = coef_reg.sens_high;
            ptc_pkg::REG_OFFSET:    rd_word = coef_reg.offset;
            default:                rd_word = '0;
        endcase
    end

    assign prdata = {{(ptc_pkg::APB_DATA_W - ptc_pkg::COEF_W){1'b0}}, rd_word};

endmodule

// ----- hdl/ptc_front.sv -----
// Front pipeline: temperature, sensitivities, fit numerator and divisor, classification.
// Depends on ptc_pkg; feeds ptc_queue.
module ptc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ptc_pkg::ptc_coef_t             coef,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ptc_pkg::RAW_T_W-1:0]    raw_temp,
    input  logic [ptc_pkg::RAW_P_W-1:0]    raw_press,
    input  logic                           q_full,
    output logic                           q_push,
    output ptc_pkg::ptc_item_t             q_item
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;
    logic              en;

    // Stage 1: temperature and squared centered temperature
    logic signed [15:0]            t_cent;
    logic signed [31:0]            tsq_full;
    logic [30:0]                   tprod;
    logic signed [15:0]            temp_wide;
    logic [ptc_pkg::TSQ_W-1:0]     tsq_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp1_reg;
    logic [ptc_pkg::RAW_P_W-1:0]   x1_reg;

    // Stage 2: sensitivities
    logic [46:0]                   prod_low, prod_mid, prod_high;
    logic [23:0]                   s1_next, s3_next;
    logic [ptc_pkg::SENS_W-1:0]    s2_next;
    logic [23:0]                   s1_reg, s3_reg;
    logic [ptc_pkg::SENS_W-1:0]    s2_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp2_reg;
    logic [ptc_pkg::RAW_P_W-1:0]   x2_reg;

    // Stage 3: differences
    logic signed [ptc_pkg::DIFF_W-1:0] a_reg, b_reg, c_reg, e_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp3_reg;

    // Stage 4: products
    logic signed [ptc_pkg::PROD_W-1:0] u_reg, v_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp4_reg;

    // Stage 5: numerator and divisor
    logic signed [ptc_pkg::NUM_W-1:0]  u_ext, v_ext;
    logic signed [ptc_pkg::NUM_W-1:0]  num_reg, den_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp5_reg;

    // Stage 6: classification
    logic                              den_neg;
    logic signed [ptc_pkg::NUM_W-1:0]  num_adj, den_adj;
    ptc_pkg::ptc_item_t                item_next, item_reg;

    // Stall the whole front while its last item waits on a full queue
    assign en       = !(valid_reg[STAGES-1] && q_full);
    assign in_ready = en;
    assign q_push   = valid_reg[STAGES-1] && !q_full;
    assign q_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    assign t_cent    = $signed({~raw_temp[15], raw_temp[14:0]});
    assign tsq_full  = t_cent * t_cent;
    assign tprod     = 31'(raw_temp) * 31'(ptc_pkg::TEMP_SCALE);
    assign temp_wide = $signed({1'b0, tprod[30:16]}) - ptc_pkg::TEMP_OFFSET;

    assign prod_low  = 47'(coef.sens_low)  * 47'(tsq_reg);
    assign prod_mid  = 47'(coef.sens_mid)  * 47'(tsq_reg);
    assign prod_high = 47'(coef.sens_high) * 47'(tsq_reg);
    assign s1_next   = ptc_pkg::SENS_LOW_BASE + 24'(prod_low[46:24]);
    assign s2_next   = ptc_pkg::SENS_W'({coef.offset, 11'b0}) + ptc_pkg::SENS_W'(prod_mid[46:24]);
    assign s3_next   = ptc_pkg::SENS_HIGH_BASE + 24'(prod_high[46:24]);

    assign u_ext = ptc_pkg::NUM_W'(u_reg);
    assign v_ext = ptc_pkg::NUM_W'(v_reg);

    // Fold the divisor sign into the numerator
    always_comb
    begin
        den_neg              = den_reg[ptc_pkg::NUM_W-1];
        num_adj              = den_neg ? -num_reg : num_reg;
        den_adj              = den_neg ? -den_reg : den_reg;
        item_next.temp_centi = temp5_reg;
        item_next.num_mag    = num_adj[ptc_pkg::MAG_W-1:0];
        item_next.den_mag    = den_adj[ptc_pkg::MAG_W-1:0];
        item_next.div_fault  = (den_reg == '0);
        item_next.positive   = !num_adj[ptc_pkg::NUM_W-1] && (num_adj != '0);
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tsq_reg   <= tsq_full[ptc_pkg::TSQ_W-1:0];
            temp1_reg <= temp_wide[ptc_pkg::TEMP_W-1:0];
            x1_reg    <= raw_press;

            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            temp2_reg <= temp1_reg;
            x2_reg    <= x1_reg;

            a_reg     <= $signed({5'b0, x2_reg}) - $signed({5'b0, s1_reg});
            b_reg     <= $signed({1'b0, s2_reg}) - $signed({5'b0, s3_reg});
            c_reg     <= $signed({5'b0, x2_reg}) - $signed({5'b0, s3_reg});
            e_reg     <= $signed({1'b0, s2_reg}) - $signed({5'b0, s1_reg});
            temp3_reg <= temp2_reg;

            u_reg     <= a_reg * b_reg;
            v_reg     <= c_reg * e_reg;
            temp4_reg <= temp3_reg;

            // 15v + 49u and 5v + 7u
            num_reg   <= (v_ext <<< 4) - v_ext + (u_ext <<< 5) + (u_ext <<< 4) + u_ext;
            den_reg   <= (v_ext <<< 2) + v_ext + (u_ext <<< 3) - u_ext;
            temp5_reg <= temp4_reg;

            item_reg  <= item_next;
        end
    end

    // A stalled last item must hold until the queue frees up
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-1] && q_full) |=> (valid_reg[STAGES-1] && $stable(item_reg)))
        else $error("front dropped or changed a stalled item");

    a_front_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

endmodule

// ----- hdl/ptc_queue.sv -----
// Short queue of classified items between the front and back pipelines.
// Depends on ptc_pkg.
module ptc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ptc_pkg::ptc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output ptc_pkg::ptc_item_t pop_item
);

    localparam int DEPTH = ptc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptc_pkg::ptc_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            priority if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else
            begin
                count_reg <= count_reg;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue lost a pushed item");

endmodule

// ----- hdl/ptc_back.sv -----
// Back pipeline: scaled quotient by restoring division, saturation, output register.
// Depends on ptc_pkg; takes items from ptc_queue.
module ptc_back #(
    parameter int FRAC_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  ptc_pkg::ptc_item_t                q_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ptc_pkg::TEMP_W-1:0] temp_centi,
    output logic [ptc_pkg::PRESS_W-1:0]       press_fixed,
    output logic                              div_fault
);

    localparam logic [ptc_pkg::KMUL_W-1:0] KMUL = ptc_pkg::KMUL_W'(15000 * (2 ** FRAC_BITS));
    localparam int QB    = ptc_pkg::PRESS_W;
    localparam int MAG_W = ptc_pkg::MAG_W;
    localparam int HI_W  = MAG_W - ptc_pkg::SPLIT_W;
    localparam int LO_P_W = ptc_pkg::SPLIT_W + ptc_pkg::KMUL_W;
    localparam int HI_P_W = HI_W + ptc_pkg::KMUL_W;
    localparam int SC_W  = ptc_pkg::SCALED_W;

    typedef struct packed {
        logic signed [ptc_pkg::TEMP_W-1:0] temp_centi;
        logic                              div_fault;
        logic                              positive;
        logic                              sat;
    } ptc_meta_t;

    logic en;

    // Scaling multiply stage
    logic                     v1_reg;
    logic [LO_P_W-1:0]        plo_reg;
    logic [HI_P_W-1:0]        phi_reg;
    logic [MAG_W-1:0]         d1_reg;
    ptc_pkg::ptc_item_t       it1_reg;

    // Sum stage
    logic                     v2_reg;
    logic [SC_W-1:0]          scaled_reg;
    logic [MAG_W-1:0]         d2_reg;
    ptc_pkg::ptc_item_t       it2_reg;

    // Division stages; index 0 is the entry after the range check
    logic [MAG_W:0]           rem0;
    logic                     vd_reg   [QB+1];
    logic [MAG_W-1:0]         rem_reg  [QB+1];
    logic [QB-1:0]            low_reg  [QB+1];
    logic [QB-1:0]            quo_reg  [QB+1];
    logic [MAG_W-1:0]         dd_reg   [QB+1];
    ptc_meta_t                meta_reg [QB+1];

    // Output register
    logic                              out_valid_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp_out_reg;
    logic [ptc_pkg::PRESS_W-1:0]       press_out_reg;
    logic                              fault_out_reg;
    logic [ptc_pkg::PRESS_W-1:0]       press_next;
    ptc_meta_t                         meta_last;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    assign out_valid   = out_valid_reg;
    assign temp_centi  = temp_out_reg;
    assign press_fixed = press_out_reg;
    assign div_fault   = fault_out_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vd_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= !q_empty;
            v2_reg        <= v1_reg;
            vd_reg[0]     <= v2_reg;
            out_valid_reg <= vd_reg[QB];
        end
    end

    assign rem0 = scaled_reg[SC_W-1:QB];

    // Multiply, sum and range check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= LO_P_W'(q_item.num_mag[ptc_pkg::SPLIT_W-1:0]) * LO_P_W'(KMUL);
            phi_reg <= HI_P_W'(q_item.num_mag[MAG_W-1:ptc_pkg::SPLIT_W]) * HI_P_W'(KMUL);
            d1_reg  <= q_item.den_mag;
            it1_reg <= q_item;

            scaled_reg <= (SC_W'(phi_reg) << ptc_pkg::SPLIT_W) + SC_W'(plo_reg);
            d2_reg     <= d1_reg;
            it2_reg    <= it1_reg;

            rem_reg[0]             <= rem0[MAG_W-1:0];
            low_reg[0]             <= scaled_reg[QB-1:0];
            quo_reg[0]             <= '0;
            dd_reg[0]              <= d2_reg;
            meta_reg[0].temp_centi <= it2_reg.temp_centi;
            meta_reg[0].div_fault  <= it2_reg.div_fault;
            meta_reg[0].positive   <= it2_reg.positive;
            // Quotient reaches 2^21 or more
            meta_reg[0].sat        <= (rem0 >= {1'b0, d2_reg});
        end
    end

    // One quotient bit per stage
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [MAG_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[j], low_reg[j][QB-1]};
        assign ge    = (trial >= {1'b0, dd_reg[j]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vd_reg[j+1] <= vd_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? MAG_W'(trial - {1'b0, dd_reg[j]}) : MAG_W'(trial);
                low_reg[j+1]  <= {low_reg[j][QB-2:0], 1'b0};
                quo_reg[j+1]  <= {quo_reg[j][QB-2:0], ge};
                dd_reg[j+1]   <= dd_reg[j];
                meta_reg[j+1] <= meta_reg[j];
            end
        end
    end

    // Clamp and select the pressure
    assign meta_last = meta_reg[QB];

    always_comb
    begin
        priority if (meta_last.div_fault || !meta_last.positive)
        begin
            press_next = '0;
        end
        else if (meta_last.sat)
        begin
            press_next = ptc_pkg::PRESS_MAX;
        end
        else
        begin
            press_next = quo_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_out_reg  <= meta_last.temp_centi;
            press_out_reg <= press_next;
            fault_out_reg <= meta_last.div_fault;
        end
    end

    a_back_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fault_out_reg) |-> (press_out_reg == '0))
        else $error("pressure not zero on divisor fault");

    a_back_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> v1_reg)
        else $error("popped item not entered in back pipeline");

endmodule

// ----- hdl/pressure_temp_compensation.sv -----
// Barometric compensation: one raw sample pair in, one result out. Accepts an item
// every cycle unless the front stalls on a full queue. An item passes six front
// stages, the queue, multiply and sum stages, a range check, 21 restoring-division
// stages producing one quotient bit each, and the output register. The front and
// back pipelines are joined by a four-entry queue, so the input keeps flowing for a
// few items after the output stalls. Calibration words sit on an APB port at byte
// addresses 0, 4, 8 and 12 and should be written while no item is in flight.
// Depends on ptc_pkg, ptc_sample_if, ptc_result_if and the ptc_* submodules.
module pressure_temp_compensation #(
    parameter int PRESSURE_FRAC_BITS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    ptc_sample_if.sink                         sample,
    ptc_result_if.source                       result
);

    ptc_pkg::ptc_coef_t coef;
    ptc_pkg::ptc_item_t push_item, pop_item;
    logic               q_push, q_full, q_pop, q_empty;

    // Calibration registers
    ptc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // Classify incoming items
    ptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .raw_temp  (sample.raw_temp),
        .raw_press (sample.raw_press),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // Decouple the two pipelines
    ptc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    // Divide, saturate and deliver
    ptc_back #(
        .FRAC_BITS (PRESSURE_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_item      (pop_item),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .temp_centi  (result.temp_centi),
        .press_fixed (result.press_fixed),
        .div_fault   (result.div_fault)
    );

endmodule
